// File: hw/rtl/message_ring_mailbox_unit_defines.svh
// Assertion macros used by the mailbox controller.
`ifndef MESSAGE_RING_MAILBOX_UNIT_DEFINES_SVH
`define MESSAGE_RING_MAILBOX_UNIT_DEFINES_SVH

// Plain property, checked at every rising clock edge outside reset.
`define MRM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MRM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/mrm_pkg.sv
// Constants, codes, types and helpers of the mailbox block.
`timescale 1ns / 1ps
package mrm_pkg;

	localparam int unsigned BOX_COUNT    = 8;
	localparam int unsigned RING_BYTES   = 256;
	localparam int unsigned HEADER_BYTES = 4;
	localparam int unsigned MAX_BODY     = 64;

	localparam int unsigned BOX_W   = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;
	localparam int unsigned PTR_W   = $clog2(RING_BYTES);
	localparam int unsigned ADDR_W  = $clog2(BOX_COUNT * RING_BYTES);
	localparam int unsigned FREE_IW = $clog2(RING_BYTES + 1);
	localparam int unsigned CMP_W   = ((FREE_IW > 7) ? FREE_IW : 7) + 1;
	localparam int unsigned SUM_W   = ((PTR_W > 7) ? PTR_W : 7) + 1;
	localparam int unsigned HCNT_W  = $clog2(HEADER_BYTES + 1);
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned USER_W  = 8;

	// actions
	localparam logic [2:0] ACT_OPEN  = 3'd0;
	localparam logic [2:0] ACT_CLOSE = 3'd1;
	localparam logic [2:0] ACT_STAT  = 3'd2;
	localparam logic [2:0] ACT_SEND  = 3'd3;
	localparam logic [2:0] ACT_RECV  = 3'd4;

	// result status
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ILLEGAL = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_NOSPACE = 3'd3;
	localparam logic [2:0] ST_BUSY    = 3'd4;

	// item classes reported by the datapath
	localparam int unsigned CLS_W = 2;
	localparam logic [CLS_W-1:0] CLS_DROP       = 2'd0;
	localparam logic [CLS_W-1:0] CLS_SIMPLE     = 2'd1;
	localparam logic [CLS_W-1:0] CLS_SEND_START = 2'd2;
	localparam logic [CLS_W-1:0] CLS_RECV       = 2'd3;

	// datapath operations
	localparam int unsigned OP_W = 3;
	localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
	localparam logic [OP_W-1:0] OP_SIMPLE     = 3'd1;
	localparam logic [OP_W-1:0] OP_HDR_FIRST  = 3'd2;
	localparam logic [OP_W-1:0] OP_HDR_ZERO   = 3'd3;
	localparam logic [OP_W-1:0] OP_SEND_FIRST = 3'd4;
	localparam logic [OP_W-1:0] OP_RX_ADDR    = 3'd5;
	localparam logic [OP_W-1:0] OP_RX_LEN     = 3'd6;
	localparam logic [OP_W-1:0] OP_RX_BYTE    = 3'd7;

	typedef struct packed {
		logic            load;
		logic [OP_W-1:0] op;
	} mrm_cmd_t;

	typedef struct packed {
		logic [CLS_W-1:0] cls;
		logic             slot_free;
		logic             hdr_last;
		logic             rx_len_zero;
		logic             rx_last;
	} mrm_stat_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(RING_BYTES - 1)) r = '0;
		else r = p + PTR_W'(1);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] ring_addr(input logic [BOX_W-1:0] box,
		input logic [PTR_W-1:0] pos);
		return ADDR_W'(ADDR_W'(box) * ADDR_W'(RING_BYTES) + ADDR_W'(pos));
	endfunction

endpackage

// File: hw/rtl/mrm_if.sv
// Handshake channels of the mailbox block: request items and result items.
`timescale 1ns / 1ps
interface mrm_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        action;
	logic signed [4:0] box_key;
	logic [6:0]        body_length;
	logic [7:0]        data_byte;

	modport source(output valid, action, box_key, body_length, data_byte, input ready);
	modport sink(input valid, action, box_key, body_length, data_byte, output ready);
endinterface

interface mrm_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [2:0] handle;
	logic [6:0] msg_count;
	logic [8:0] free_space;
	logic [6:0] out_length;
	logic [7:0] out_byte;
	logic       out_last;

	modport source(output valid, status, handle, msg_count, free_space, out_length,
		out_byte, out_last, input ready);
	modport sink(input valid, status, handle, msg_count, free_space, out_length,
		out_byte, out_last, output ready);
endinterface

// File: hw/rtl/message_ring_mailbox_unit.sv
// Top level of the mailbox block.
`timescale 1ns / 1ps
// Eight mailboxes, each a 256-byte ring of length-prefixed messages, all in one
// single-port-write, single-port-read ring RAM. One request beat is handled at a
// time. Open, close, stat, rejected items and each continuing send byte are
// accepted, then executed. The first send beat of a message also writes the
// HEADER_BYTES header bytes, one at a time through the RAM write port, before its
// first body byte. A receive first fetches the length byte, then returns one body
// byte per cycle, paced by the RAM read port and by the result side. A result
// waits in an output register while the next beat is accepted. No clearing pass
// after reset: ring bytes are read only after they were written.
module message_ring_mailbox_unit (
	input logic      clk,
	input logic      arst_n,
	mrm_req_if.sink  req,
	mrm_rsp_if.source rsp
);
	mrm_pkg::mrm_cmd_t  cmd;
	mrm_pkg::mrm_stat_t st;
	logic               in_ready;

	assign req.ready = in_ready;

	mrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (req.valid && in_ready),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	mrm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.action      (req.action),
		.box_key     (req.box_key),
		.body_length (req.body_length),
		.data_byte   (req.data_byte),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.status      (rsp.status),
		.handle      (rsp.handle),
		.msg_count   (rsp.msg_count),
		.free_space  (rsp.free_space),
		.out_length  (rsp.out_length),
		.out_byte    (rsp.out_byte),
		.out_last    (rsp.out_last)
	);
endmodule

// File: hw/rtl/mrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mrm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: hw/rtl/mrm_dp.sv
// Mailbox datapath: box pointers and counts, send and receive state, ring RAM, result register.
`timescale 1ns / 1ps
module mrm_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mrm_pkg::mrm_cmd_t   cmd,
	output mrm_pkg::mrm_stat_t  st,
	input  logic [2:0]          action,
	input  logic signed [4:0]   box_key,
	input  logic [6:0]          body_length,
	input  logic [7:0]          data_byte,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [2:0]          status,
	output logic [2:0]          handle,
	output logic [6:0]          msg_count,
	output logic [8:0]          free_space,
	output logic [6:0]          out_length,
	output logic [7:0]          out_byte,
	output logic                out_last
);
	localparam int unsigned PW = mrm_pkg::PTR_W;

	// latched item
	logic [2:0]        act_q;
	logic signed [4:0] key_q;
	logic [6:0]        blen_q;
	logic [7:0]        data_q;

	logic [PW-1:0]               head_q  [mrm_pkg::BOX_COUNT];
	logic [PW-1:0]               tail_q  [mrm_pkg::BOX_COUNT];
	logic [mrm_pkg::CNT_W-1:0]   cnt_q   [mrm_pkg::BOX_COUNT];
	logic [mrm_pkg::USER_W-1:0]  users_q [mrm_pkg::BOX_COUNT];

	logic                        send_active_q;
	logic [mrm_pkg::BOX_W-1:0]   send_box_q;
	logic [6:0]                  send_rem_q;
	logic [PW-1:0]               send_pos_q;
	logic [mrm_pkg::HCNT_W-1:0]  hdr_cnt_q;
	logic [PW-1:0]               rx_pos_q;
	logic [6:0]                  rx_len_q;
	logic [6:0]                  rx_idx_q;

	logic       out_valid_q;
	logic [2:0] out_status_q;
	logic [2:0] out_handle_q;
	logic [6:0] out_cnt_q;
	logic [8:0] out_free_q;
	logic [6:0] out_len_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic [mrm_pkg::BOX_W-1:0]   b;
	logic                        key_ok;
	logic [PW-1:0]               cur_head, cur_tail;
	logic [mrm_pkg::CNT_W-1:0]   cur_cnt;
	logic [mrm_pkg::USER_W-1:0]  cur_users;
	logic [mrm_pkg::FREE_IW-1:0] free_c;
	logic                        space_ok, send_match;
	logic [PW:0]                 body_sum;
	logic [PW-1:0]               body_pos;
	logic [mrm_pkg::SUM_W-1:0]   tail_sum;
	logic [PW-1:0]               tail_new;
	logic [6:0]                  len_c;
	logic                        rx_last_c;
	logic [PW-1:0]               send_pos_inc;
	logic [mrm_pkg::CLS_W-1:0]   cls_c;

	logic                        ram_we, ram_re;
	logic [mrm_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [7:0]                  ram_wdata, ram_rdata;

	logic       emit;
	logic [2:0] res_status, res_handle;
	logic [6:0] res_cnt, res_len;
	logic [8:0] res_free;
	logic [7:0] res_byte;
	logic       res_last;

	assign b         = key_q[mrm_pkg::BOX_W-1:0];
	assign key_ok    = !key_q[4] && ({1'b0, key_q[3:0]} < 5'(mrm_pkg::BOX_COUNT));
	assign cur_head  = head_q[b];
	assign cur_tail  = tail_q[b];
	assign cur_cnt   = cnt_q[b];
	assign cur_users = users_q[b];
	assign send_match   = send_box_q == b;
	assign send_pos_inc = mrm_pkg::ptr_inc(send_pos_q);

	// free ring bytes; head equal to tail is full when messages are held
	always_comb begin
		if (cur_head == cur_tail)
			free_c = (cur_cnt != '0) ? '0 : mrm_pkg::FREE_IW'(mrm_pkg::RING_BYTES);
		else if (cur_tail > cur_head)
			free_c = mrm_pkg::FREE_IW'(cur_tail) - mrm_pkg::FREE_IW'(cur_head);
		else
			free_c = mrm_pkg::FREE_IW'(cur_tail) + mrm_pkg::FREE_IW'(mrm_pkg::RING_BYTES)
				- mrm_pkg::FREE_IW'(cur_head);
	end

	assign space_ok = (blen_q <= 7'(mrm_pkg::MAX_BODY)) &&
		(mrm_pkg::CMP_W'(mrm_pkg::HEADER_BYTES) + mrm_pkg::CMP_W'(blen_q)
			<= mrm_pkg::CMP_W'(free_c));

	// receive: first body byte follows the header; body length is header byte zero
	assign body_sum = {1'b0, cur_tail} + (PW+1)'(mrm_pkg::HEADER_BYTES);
	assign body_pos = (body_sum >= (PW+1)'(mrm_pkg::RING_BYTES)) ?
		PW'(body_sum - (PW+1)'(mrm_pkg::RING_BYTES)) : PW'(body_sum);
	assign len_c = (ram_rdata > 8'(mrm_pkg::MAX_BODY)) ? 7'(mrm_pkg::MAX_BODY) : ram_rdata[6:0];
	assign tail_sum = mrm_pkg::SUM_W'(body_pos) + mrm_pkg::SUM_W'(len_c);
	assign tail_new = (tail_sum >= mrm_pkg::SUM_W'(mrm_pkg::RING_BYTES)) ?
		PW'(tail_sum - mrm_pkg::SUM_W'(mrm_pkg::RING_BYTES)) : PW'(tail_sum);
	assign rx_last_c = (rx_idx_q + 7'd1) == rx_len_q;

	always_comb begin
		if (act_q > mrm_pkg::ACT_RECV) cls_c = mrm_pkg::CLS_DROP;
		else if (!key_ok) cls_c = mrm_pkg::CLS_SIMPLE;
		else if (act_q == mrm_pkg::ACT_SEND)
			cls_c = (!send_active_q && space_ok) ? mrm_pkg::CLS_SEND_START
				: mrm_pkg::CLS_SIMPLE;
		else if (act_q == mrm_pkg::ACT_RECV)
			cls_c = (cur_cnt != '0) ? mrm_pkg::CLS_RECV : mrm_pkg::CLS_SIMPLE;
		else cls_c = mrm_pkg::CLS_SIMPLE;
	end
	assign st.cls         = cls_c;
	assign st.slot_free   = !out_valid_q || out_ready;
	assign st.hdr_last    = hdr_cnt_q == mrm_pkg::HCNT_W'(mrm_pkg::HEADER_BYTES - 1);
	assign st.rx_len_zero = ram_rdata == 8'd0;
	assign st.rx_last     = rx_last_c;

	always_comb begin
		emit       = 1'b0;
		res_status = mrm_pkg::ST_OK;
		res_handle = '0;
		res_cnt    = '0;
		res_free   = '0;
		res_len    = '0;
		res_byte   = '0;
		res_last   = 1'b1;
		ram_we     = 1'b0;
		ram_waddr  = mrm_pkg::ring_addr(send_box_q, send_pos_q);
		ram_wdata  = data_q;
		ram_re     = 1'b0;
		ram_raddr  = mrm_pkg::ring_addr(b, cur_tail);
		unique case (cmd.op)
			mrm_pkg::OP_SIMPLE: begin
				emit = 1'b1;
				if (!key_ok) begin
					res_status = mrm_pkg::ST_ILLEGAL;
				end else begin
					unique case (act_q)
						mrm_pkg::ACT_OPEN: res_handle = 3'(b);
						mrm_pkg::ACT_STAT: begin
							res_cnt  = 7'(cur_cnt);
							res_free = 9'(free_c);
						end
						mrm_pkg::ACT_SEND: begin
							if (!send_active_q) res_status = mrm_pkg::ST_NOSPACE;
							else if (!send_match) res_status = mrm_pkg::ST_BUSY;
							else ram_we = 1'b1;
						end
						mrm_pkg::ACT_RECV: res_status = mrm_pkg::ST_EMPTY;
						default: ;
					endcase
				end
			end
			mrm_pkg::OP_HDR_FIRST: begin
				ram_we    = 1'b1;
				ram_waddr = mrm_pkg::ring_addr(b, cur_head);
				ram_wdata = 8'(blen_q);
			end
			mrm_pkg::OP_HDR_ZERO: begin
				ram_we    = 1'b1;
				ram_wdata = 8'd0;
			end
			mrm_pkg::OP_SEND_FIRST: begin
				emit   = 1'b1;
				ram_we = blen_q != 7'd0;
			end
			mrm_pkg::OP_RX_ADDR: ram_re = 1'b1;
			mrm_pkg::OP_RX_LEN: begin
				if (len_c == 7'd0) begin
					emit = 1'b1;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = mrm_pkg::ring_addr(b, body_pos);
				end
			end
			mrm_pkg::OP_RX_BYTE: begin
				emit      = 1'b1;
				res_len   = rx_len_q;
				res_byte  = ram_rdata;
				res_last  = rx_last_c;
				ram_re    = !rx_last_c;
				ram_raddr = mrm_pkg::ring_addr(b, rx_pos_q);
			end
			default: ;
		endcase
	end

	mrm_ram #(.WIDTH(8), .DEPTH(mrm_pkg::BOX_COUNT * mrm_pkg::RING_BYTES)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			key_q  <= box_key;
			blen_q <= body_length;
			data_q <= data_byte;
		end
		if (emit) begin
			out_status_q <= res_status;
			out_handle_q <= res_handle;
			out_cnt_q    <= res_cnt;
			out_free_q   <= res_free;
			out_len_q    <= res_len;
			out_byte_q   <= res_byte;
			out_last_q   <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(mrm_pkg::BOX_COUNT); i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				cnt_q[i]   <= '0;
				users_q[i] <= '0;
			end
			send_active_q <= 1'b0;
			send_box_q    <= '0;
			send_rem_q    <= '0;
			send_pos_q    <= '0;
			hdr_cnt_q     <= '0;
			rx_pos_q      <= '0;
			rx_len_q      <= '0;
			rx_idx_q      <= '0;
		end else begin
			unique case (cmd.op)
				mrm_pkg::OP_SIMPLE: begin
					if (key_ok) begin
						unique case (act_q)
							mrm_pkg::ACT_OPEN: begin
								if (cur_users == '0) begin
									head_q[b] <= '0;
									tail_q[b] <= '0;
									cnt_q[b]  <= '0;
									// drop a send left open on the reopened box
									if (send_active_q && send_match) begin
										send_active_q <= 1'b0;
										send_rem_q    <= '0;
									end
								end
								if (cur_users != '1) users_q[b] <= cur_users + 1'b1;
							end
							mrm_pkg::ACT_CLOSE: begin
								if (cur_users != '0) users_q[b] <= cur_users - 1'b1;
							end
							mrm_pkg::ACT_SEND: begin
								if (send_active_q && send_match) begin
									send_pos_q <= send_pos_inc;
									if (send_rem_q == 7'd1) begin
										head_q[send_box_q] <= send_pos_inc;
										cnt_q[send_box_q]  <= cnt_q[send_box_q] + 1'b1;
										send_active_q      <= 1'b0;
										send_rem_q         <= '0;
									end else begin
										send_rem_q <= send_rem_q - 7'd1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				mrm_pkg::OP_HDR_FIRST: begin
					send_box_q    <= b;
					send_active_q <= 1'b1;
					send_pos_q    <= mrm_pkg::ptr_inc(cur_head);
					send_rem_q    <= blen_q;
					hdr_cnt_q     <= mrm_pkg::HCNT_W'(1);
				end
				mrm_pkg::OP_HDR_ZERO: begin
					send_pos_q <= send_pos_inc;
					hdr_cnt_q  <= hdr_cnt_q + 1'b1;
				end
				mrm_pkg::OP_SEND_FIRST: begin
					if (blen_q == 7'd0) begin
						head_q[send_box_q] <= send_pos_q;
						cnt_q[send_box_q]  <= cnt_q[send_box_q] + 1'b1;
						send_active_q      <= 1'b0;
						send_rem_q         <= '0;
					end else begin
						send_pos_q <= send_pos_inc;
						if (blen_q == 7'd1) begin
							head_q[send_box_q] <= send_pos_inc;
							cnt_q[send_box_q]  <= cnt_q[send_box_q] + 1'b1;
							send_active_q      <= 1'b0;
							send_rem_q         <= '0;
						end else begin
							send_rem_q <= blen_q - 7'd1;
						end
					end
				end
				mrm_pkg::OP_RX_LEN: begin
					tail_q[b] <= tail_new;
					cnt_q[b]  <= cur_cnt - 1'b1;
					rx_len_q  <= len_c;
					rx_pos_q  <= mrm_pkg::ptr_inc(body_pos);
					rx_idx_q  <= '0;
				end
				mrm_pkg::OP_RX_BYTE: begin
					if (!rx_last_c) begin
						rx_pos_q <= mrm_pkg::ptr_inc(rx_pos_q);
						rx_idx_q <= rx_idx_q + 7'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign handle     = out_handle_q;
	assign msg_count  = out_cnt_q;
	assign free_space = out_free_q;
	assign out_length = out_len_q;
	assign out_byte   = out_byte_q;
	assign out_last   = out_last_q;
endmodule

// File: hw/rtl/mrm_ctrl.sv
// Mailbox controller: sequences each item through the datapath.
`timescale 1ns / 1ps
`include "message_ring_mailbox_unit_defines.svh"
module mrm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	output logic               in_ready,
	input  mrm_pkg::mrm_stat_t st,
	output mrm_pkg::mrm_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_HDR    = 3'd2;
	localparam logic [2:0] S_SFIRST = 3'd3;
	localparam logic [2:0] S_RLEN   = 3'd4;
	localparam logic [2:0] S_RX     = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.op   = mrm_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (st.cls)
					mrm_pkg::CLS_DROP: state_d = S_IDLE;
					mrm_pkg::CLS_SIMPLE: begin
						if (st.slot_free) begin
							cmd.op  = mrm_pkg::OP_SIMPLE;
							state_d = S_IDLE;
						end
					end
					mrm_pkg::CLS_SEND_START: begin
						cmd.op  = mrm_pkg::OP_HDR_FIRST;
						state_d = (mrm_pkg::HEADER_BYTES > 1) ? S_HDR : S_SFIRST;
					end
					mrm_pkg::CLS_RECV: begin
						cmd.op  = mrm_pkg::OP_RX_ADDR;
						state_d = S_RLEN;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_HDR: begin
				cmd.op = mrm_pkg::OP_HDR_ZERO;
				if (st.hdr_last) state_d = S_SFIRST;
			end
			S_SFIRST: begin
				if (st.slot_free) begin
					cmd.op  = mrm_pkg::OP_SEND_FIRST;
					state_d = S_IDLE;
				end
			end
			S_RLEN: begin
				// an empty body answers once the result slot is free; otherwise start the byte run
				if (!st.rx_len_zero) begin
					cmd.op  = mrm_pkg::OP_RX_LEN;
					state_d = S_RX;
				end else if (st.slot_free) begin
					cmd.op  = mrm_pkg::OP_RX_LEN;
					state_d = S_IDLE;
				end
			end
			S_RX: begin
				if (st.slot_free) begin
					cmd.op = mrm_pkg::OP_RX_BYTE;
					if (st.rx_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	`MRM_ASSERT_NXT(a_accept_exec, clk, arst_n, in_fire, state_q == S_EXEC, "accepted beat not executed")
	`MRM_ASSERT_NXT(a_rx_done, clk, arst_n, cmd.op == mrm_pkg::OP_RX_BYTE && st.rx_last, state_q == S_IDLE, "receive run did not end")
	`MRM_ASSERT(a_emit_slot, clk, arst_n, cmd.op != mrm_pkg::OP_SEND_FIRST || st.slot_free, "result issued into a full slot")
endmodule

// File: bench/tb_message_ring_mailbox_unit.sv
// Self-checking testbench of the mailbox block: table-driven directed beats, then random traffic.
`timescale 1ns / 1ps
module tb_message_ring_mailbox_unit;

	localparam int unsigned IDLE_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] handle;
		logic [6:0] msg_count;
		logic [8:0] free_space;
		logic [6:0] out_length;
		logic [7:0] out_byte;
		logic       out_last;
	} mbox_result_t;

	typedef struct packed {
		logic [2:0] action;
		logic [4:0] box_key;
		logic [6:0] body_length;
		logic [7:0] data_byte;
	} mbox_req_t;

	// Directed rows; a typed result is checked in addition to the predictor.
	typedef struct packed {
		mbox_req_t    req;
		logic         typed;
		mbox_result_t res;
	} mbox_row_t;

	logic clk;
	logic arst_n;
	mrm_req_if req ();
	mrm_rsp_if rsp ();

	message_ring_mailbox_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Predictor state
	logic [7:0] ring_mem [mrm_pkg::BOX_COUNT][mrm_pkg::RING_BYTES];
	logic [7:0] head_pos [mrm_pkg::BOX_COUNT];
	logic [7:0] tail_pos [mrm_pkg::BOX_COUNT];
	int unsigned msgs_held [mrm_pkg::BOX_COUNT];
	int unsigned users [mrm_pkg::BOX_COUNT];
	logic       tx_open;
	int unsigned tx_box;
	int unsigned tx_left;
	logic [7:0] tx_pos;

	mbox_result_t expected_results [$];
	int unsigned error_count;
	int unsigned idle_cycles;
	bit          stim_done;
	bit          hold_off;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic mbox_result_t plain_result(input logic [2:0] st);
		mbox_result_t r;
		r = '0;
		r.status = st;
		r.out_last = 1'b1;
		return r;
	endfunction

	function automatic int unsigned ring_free(input int unsigned b);
		if (head_pos[b] == tail_pos[b] && msgs_held[b] != 0) return 0;
		if (tail_pos[b] > head_pos[b]) return tail_pos[b] - head_pos[b];
		return tail_pos[b] + mrm_pkg::RING_BYTES - head_pos[b];
	endfunction

	function automatic void close_message();
		head_pos[tx_box] = tx_pos;
		msgs_held[tx_box]++;
		tx_open = 1'b0;
		tx_left = 0;
	endfunction

	// Apply one accepted beat to the mailbox model and queue its results.
	function automatic void predict_mailbox(input mbox_req_t q);
		int key;
		int unsigned b, len;
		logic [7:0] pos;
		mbox_result_t r;
		key = $signed(q.box_key);
		if (q.action > mrm_pkg::ACT_RECV) return;
		if (key < 0 || key >= mrm_pkg::BOX_COUNT) begin
			expected_results.push_back(plain_result(mrm_pkg::ST_ILLEGAL));
			return;
		end
		b = key;
		case (q.action)
			mrm_pkg::ACT_OPEN: begin
				if (users[b] == 0) begin
					head_pos[b] = 0;
					tail_pos[b] = 0;
					msgs_held[b] = 0;
					if (tx_open && tx_box == b) begin
						tx_open = 1'b0;
						tx_left = 0;
					end
				end
				if (users[b] < 255) users[b]++;
				r = plain_result(mrm_pkg::ST_OK);
				r.handle = 3'(b);
				expected_results.push_back(r);
			end
			mrm_pkg::ACT_CLOSE: begin
				if (users[b] > 0) users[b]--;
				expected_results.push_back(plain_result(mrm_pkg::ST_OK));
			end
			mrm_pkg::ACT_STAT: begin
				r = plain_result(mrm_pkg::ST_OK);
				r.msg_count = 7'(msgs_held[b]);
				r.free_space = 9'(ring_free(b));
				expected_results.push_back(r);
			end
			mrm_pkg::ACT_SEND: begin
				if (tx_open) begin
					if (tx_box != b) begin
						expected_results.push_back(plain_result(mrm_pkg::ST_BUSY));
						return;
					end
					ring_mem[b][tx_pos] = q.data_byte;
					tx_pos++;
					tx_left--;
					if (tx_left == 0) close_message();
					expected_results.push_back(plain_result(mrm_pkg::ST_OK));
					return;
				end
				if (q.body_length > mrm_pkg::MAX_BODY ||
					mrm_pkg::HEADER_BYTES + q.body_length > ring_free(b)) begin
					expected_results.push_back(plain_result(mrm_pkg::ST_NOSPACE));
					return;
				end
				pos = head_pos[b];
				for (int k = 0; k < mrm_pkg::HEADER_BYTES; k++) begin
					ring_mem[b][pos] = 8'((32'(q.body_length) >> (8 * k)) & 32'hFF);
					pos++;
				end
				tx_box = b;
				tx_pos = pos;
				tx_open = 1'b1;
				tx_left = q.body_length;
				if (tx_left > 0) begin
					ring_mem[b][tx_pos] = q.data_byte;
					tx_pos++;
					tx_left--;
				end
				if (tx_left == 0) close_message();
				expected_results.push_back(plain_result(mrm_pkg::ST_OK));
			end
			default: begin
				if (msgs_held[b] == 0) begin
					expected_results.push_back(plain_result(mrm_pkg::ST_EMPTY));
					return;
				end
				len = 0;
				pos = tail_pos[b];
				for (int k = 0; k < mrm_pkg::HEADER_BYTES; k++) begin
					len |= 32'(ring_mem[b][pos]) << (8 * k);
					pos++;
				end
				if (len > mrm_pkg::MAX_BODY) len = mrm_pkg::MAX_BODY;
				tail_pos[b] = 8'(pos + len);
				msgs_held[b]--;
				if (len == 0) begin
					expected_results.push_back(plain_result(mrm_pkg::ST_OK));
					return;
				end
				for (int k = 0; k < len; k++) begin
					r = '0;
					r.out_length = 7'(len);
					r.out_byte = ring_mem[b][pos];
					r.out_last = (k + 1 == len);
					expected_results.push_back(r);
					pos++;
				end
			end
		endcase
	endfunction

	// Drive one beat from the falling edge and hold it until accepted.
	task automatic send_beat(input mbox_req_t q);
		req.valid <= 1'b1;
		req.action <= q.action;
		req.box_key <= q.box_key;
		req.body_length <= q.body_length;
		req.data_byte <= q.data_byte;
		do @(posedge clk); while (!req.ready);
		predict_mailbox(q);
		@(negedge clk);
	endtask

	task automatic pause_beats(input int unsigned n);
		req.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic mbox_req_t make_req(input logic [2:0] a, input int key,
		input int unsigned blen, input int unsigned d);
		mbox_req_t q;
		q.action = a;
		q.box_key = 5'(key);
		q.body_length = 7'(blen);
		q.data_byte = 8'(d);
		return q;
	endfunction

	// Send a whole message to a box: first beat carries the length.
	task automatic send_message(input int key, input int unsigned blen, input bit gappy);
		int unsigned beats;
		beats = (blen == 0) ? 1 : blen;
		for (int i = 0; i < beats; i++) begin
			send_beat(make_req(mrm_pkg::ACT_SEND, key, (i == 0) ? blen : $urandom_range(127),
				$urandom_range(255)));
			if (gappy && $urandom_range(7) == 0) pause_beats($urandom_range(4, 1));
		end
	endtask

	// Result side: random stall pattern, long hold-off on request.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) rsp.ready <= 1'b0;
			else if (stim_done) rsp.ready <= 1'b1;
			else case ($urandom_range(3))
				0: rsp.ready <= ($urandom_range(3) == 0);
				1: rsp.ready <= 1'b1;
				default: rsp.ready <= ($urandom_range(3) != 0);
			endcase
		end
	end

	// Result checking against the oldest expectation
	always @(posedge clk) begin
		mbox_result_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = {rsp.status, rsp.handle, rsp.msg_count, rsp.free_space,
				rsp.out_length, rsp.out_byte, rsp.out_last};
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got));
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.handle !== want.handle)
					report_mismatch($sformatf("handle %0d, want %0d", got.handle, want.handle));
				if (got.msg_count !== want.msg_count)
					report_mismatch($sformatf("msg_count %0d, want %0d",
						got.msg_count, want.msg_count));
				if (got.free_space !== want.free_space)
					report_mismatch($sformatf("free_space %0d, want %0d",
						got.free_space, want.free_space));
				if (got.out_length !== want.out_length)
					report_mismatch($sformatf("out_length %0d, want %0d",
						got.out_length, want.out_length));
				if (got.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %h, want %h",
						got.out_byte, want.out_byte));
				if (got.out_last !== want.out_last)
					report_mismatch($sformatf("out_last %b, want %b",
						got.out_last, want.out_last));
			end
		end
	end

	// Watchdog: cycles without any beat on either side
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
			$display("tb_message_ring_mailbox_unit: done, errors");
			$finish;
		end
	end

	mbox_row_t directed [] = '{
		'{make_req(mrm_pkg::ACT_STAT, 0, 0, 0), 1'b1,
			'{mrm_pkg::ST_OK, 3'd0, 7'd0, 9'd256, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_RECV, 7, 0, 0), 1'b1,
			'{mrm_pkg::ST_EMPTY, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_OPEN, -16, 0, 0), 1'b1,
			'{mrm_pkg::ST_ILLEGAL, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_OPEN, 15, 0, 0), 1'b1,
			'{mrm_pkg::ST_ILLEGAL, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_STAT, -1, 0, 0), 1'b1,
			'{mrm_pkg::ST_ILLEGAL, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_OPEN, 7, 0, 0), 1'b1,
			'{mrm_pkg::ST_OK, 3'd7, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_OPEN, 0, 0, 0), 1'b1,
			'{mrm_pkg::ST_OK, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_SEND, 0, 65, 8'hAA), 1'b1,
			'{mrm_pkg::ST_NOSPACE, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_SEND, 0, 127, 8'h00), 1'b1,
			'{mrm_pkg::ST_NOSPACE, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_SEND, 0, 0, 8'hFF), 1'b1,
			'{mrm_pkg::ST_OK, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_STAT, 0, 0, 0), 1'b1,
			'{mrm_pkg::ST_OK, 3'd0, 7'd1, 9'd252, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_RECV, 0, 0, 0), 1'b1,
			'{mrm_pkg::ST_OK, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_SEND, 7, 2, 8'hFF), 1'b0, '0},
		'{make_req(mrm_pkg::ACT_SEND, 0, 1, 8'h11), 1'b1,
			'{mrm_pkg::ST_BUSY, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_SEND, 7, 99, 8'h00), 1'b0, '0},
		'{make_req(mrm_pkg::ACT_RECV, 7, 0, 0), 1'b0, '0},
		'{make_req(mrm_pkg::ACT_SEND, 5, 1, 8'h5A), 1'b0, '0},
		'{make_req(3'd5, 0, 0, 0), 1'b0, '0},
		'{make_req(3'd7, 0, 127, 255), 1'b0, '0},
		'{make_req(mrm_pkg::ACT_SEND, 3, 2, 8'h01), 1'b0, '0},
		'{make_req(mrm_pkg::ACT_OPEN, 3, 0, 0), 1'b0, '0},
		'{make_req(mrm_pkg::ACT_STAT, 3, 0, 0), 1'b0, '0},
		'{make_req(mrm_pkg::ACT_CLOSE, 0, 0, 0), 1'b0, '0},
		'{make_req(mrm_pkg::ACT_CLOSE, 0, 0, 0), 1'b1,
			'{mrm_pkg::ST_OK, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}},
		'{make_req(mrm_pkg::ACT_CLOSE, 14, 0, 0), 1'b1,
			'{mrm_pkg::ST_ILLEGAL, 3'd0, 7'd0, 9'd0, 7'd0, 8'd0, 1'b1}}
	};

	// Drop valid and wait until every expected result has come.
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		mbox_row_t row;
		int unsigned sent, key, blen, pick;
		error_count = 0;
		stim_done = 1'b0;
		hold_off = 1'b0;
		tx_open = 1'b0;
		tx_box = 0;
		tx_left = 0;
		tx_pos = 0;
		for (int b = 0; b < mrm_pkg::BOX_COUNT; b++) begin
			head_pos[b] = 0;
			tail_pos[b] = 0;
			msgs_held[b] = 0;
			users[b] = 0;
		end
		req.valid = 1'b0;
		req.action = mrm_pkg::ACT_STAT;
		req.box_key = '0;
		req.body_length = '0;
		req.data_byte = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			row = directed[i];
			send_beat(row.req);
			if (row.typed && expected_results[$] !== row.res)
				report_mismatch($sformatf("directed row %0d predicts %h, table says %h",
					i, expected_results[$], row.res));
		end
		// The send on box 3 was dropped by its reopen; this starts an empty message.
		send_beat(make_req(mrm_pkg::ACT_SEND, 3, 0, 8'h02));
		// Fill box 5 to exactly full: one 60-byte message and 48 empty ones use 256 bytes.
		send_beat(make_req(mrm_pkg::ACT_OPEN, 5, 0, 0));
		wait_drained();
		send_message(5, 60, 1'b0);
		for (int m = 0; m < 48; m++) send_message(5, 0, 1'b0);
		send_beat(make_req(mrm_pkg::ACT_STAT, 5, 0, 0));
		send_beat(make_req(mrm_pkg::ACT_SEND, 5, 0, 0));
		// Long receiver hold-off while receives pile up results.
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int m = 0; m < 5; m++) send_beat(make_req(mrm_pkg::ACT_RECV, 5, 0, 0));
		join
		wait_drained();

		for (int b = 0; b < mrm_pkg::BOX_COUNT; b++)
			send_beat(make_req(mrm_pkg::ACT_OPEN, b, 0, 0));
		sent = 0;
		while (sent < 170) begin
			pick = $urandom_range(99);
			key = $urandom_range(7);
			if (pick < 45) begin
				blen = ($urandom_range(9) == 0) ? $urandom_range(64, 40) : $urandom_range(8);
				send_message(key, blen, 1'b1);
				sent += (blen == 0) ? 1 : blen;
			end else if (pick < 75) begin
				send_beat(make_req(mrm_pkg::ACT_RECV, key, $urandom_range(127),
					$urandom_range(255)));
				sent++;
			end else if (pick < 85) begin
				send_beat(make_req(mrm_pkg::ACT_STAT, key, $urandom_range(127),
					$urandom_range(255)));
				sent++;
			end else if (pick < 90) begin
				send_beat(make_req($urandom_range(1) ? mrm_pkg::ACT_OPEN : mrm_pkg::ACT_CLOSE,
					key, 0, 0));
				sent++;
			end else begin
				// noise: bad keys, odd actions, broken sends
				send_beat(make_req(3'($urandom_range(7)), int'($urandom_range(31)) - 16,
					$urandom_range(127), $urandom_range(255)));
				sent++;
			end
			if ($urandom_range(5) == 0) pause_beats($urandom_range(12, 1));
			if (sent > 80 && sent < 95) begin
				pause_beats(1);
				wait_drained();
			end
		end
		pause_beats(1);
		stim_done = 1'b1;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0) $display("tb_message_ring_mailbox_unit: done, clean");
		else $display("tb_message_ring_mailbox_unit: done, errors");
		$finish;
	end
endmodule
